FILE: rtl/core/tlvd_pkg.sv
// Shared types, codes and constant tables for the TLV payload deframer.
package tlvd_pkg;

  localparam logic [4:0] EXEC_FIELDS  = 5'd19;
  localparam logic [4:0] FETCH_FIELDS = 5'd5;
  localparam int unsigned HDR_BYTES   = 6;
  localparam int unsigned COUNT_W     = 33;
  localparam int unsigned SIZE_FLAGS  = 19;
  localparam int unsigned BLOB_FLAGS  = 4;

  localparam logic [4:0] EXEC_BLOB_FIRST = 5'd7;
  localparam logic [4:0] EXEC_BLOB_LAST  = 5'd10;
  localparam logic [4:0] FETCH_BOOL_ID   = 5'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_REVISION      = 2'd0;
  localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd1;
  localparam logic [1:0] REG_BLOB_LIMIT    = 2'd2;

  // Final status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_RESOURCE = 2'd2;

  typedef enum logic [2:0] {
    PH_REV_LO,
    PH_REV_HI,
    PH_HEAD,
    PH_VALUE,
    PH_DONE,
    PH_ERR
  } phase_t;

  // Parser state after the current byte, as seen by the status logic.
  typedef struct packed {
    logic [COUNT_W-1:0]    count;
    phase_t                phase;
    logic                  layout;
    logic [4:0]            exp_id;
    logic                  se_valid;
    logic [4:0]            se_field;
    logic [SIZE_FLAGS-1:0] size_bad;
    logic [BLOB_FLAGS-1:0] blob_bad;
    logic                  bool_bad;
  } snap_t;

  // Fixed value length of each execute field; 0 means variable (no check).
  function automatic logic [4:0] exec_size(input logic [4:0] id);
    logic [4:0] sz;
    case (id)
      5'd1:    sz = 5'd1;
      5'd2:    sz = 5'd16;
      5'd3:    sz = 5'd16;
      5'd4:    sz = 5'd8;
      5'd5:    sz = 5'd16;
      5'd6:    sz = 5'd8;
      5'd11:   sz = 5'd16;
      5'd12:   sz = 5'd2;
      5'd13:   sz = 5'd8;
      5'd14:   sz = 5'd8;
      5'd15:   sz = 5'd8;
      5'd16:   sz = 5'd16;
      5'd17:   sz = 5'd16;
      5'd18:   sz = 5'd16;
      5'd19:   sz = 5'd16;
      default: sz = 5'd0;
    endcase
    return sz;
  endfunction

endpackage

FILE: rtl/core/tlvd_parse.sv
// Byte-level parser state: revision, headers, value extents and check flags.
module tlvd_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 kind,
  input  logic [7:0]           data,
  input  logic                 last,
  input  logic [15:0]          revision_expected,
  input  logic [31:0]          blob_limit,
  output tlvd_pkg::snap_t      snap,
  output logic [4:0]           fnum,
  output logic                 inval
);

  logic [tlvd_pkg::COUNT_W-1:0]    byte_count, byte_count_next;
  tlvd_pkg::phase_t                phase, phase_next;
  logic                            layout, layout_next;
  logic [7:0]                      rev_low, rev_low_next;
  logic [2:0]                      hdr_idx, hdr_idx_next;
  logic [4:0]                      exp_id, exp_id_next;
  logic [15:0]                     hdr_id, hdr_id_next;
  logic [31:0]                     bytes_left, bytes_left_next;
  logic                            se_valid, se_valid_next;
  logic [4:0]                      se_field, se_field_next;
  logic [tlvd_pkg::SIZE_FLAGS-1:0] size_bad, size_bad_next;
  logic [tlvd_pkg::BLOB_FLAGS-1:0] blob_bad, blob_bad_next;
  logic                            bool_bad, bool_bad_next;

  logic       field_end;
  logic [4:0] total;
  logic [4:0] sz;
  logic [4:0] blob_bit;

  always_comb begin
    byte_count_next = byte_count;
    phase_next      = phase;
    layout_next     = layout;
    rev_low_next    = rev_low;
    hdr_idx_next    = hdr_idx;
    exp_id_next     = exp_id;
    hdr_id_next     = hdr_id;
    bytes_left_next = bytes_left;
    se_valid_next   = se_valid;
    se_field_next   = se_field;
    size_bad_next   = size_bad;
    blob_bad_next   = blob_bad;
    bool_bad_next   = bool_bad;
    field_end       = 1'b0;
    sz              = tlvd_pkg::exec_size(exp_id);
    blob_bit        = exp_id - tlvd_pkg::EXEC_BLOB_FIRST;

    // Latch the layout on the first byte of a payload.
    if (byte_count == '0) begin
      layout_next = kind;
    end
    total = layout_next ? tlvd_pkg::FETCH_FIELDS : tlvd_pkg::EXEC_FIELDS;
    if (byte_count != {tlvd_pkg::COUNT_W{1'b1}}) begin
      byte_count_next = byte_count + 1'b1;
    end

    case (phase)
      tlvd_pkg::PH_REV_LO: begin
        rev_low_next = data;
        phase_next   = tlvd_pkg::PH_REV_HI;
      end
      tlvd_pkg::PH_REV_HI: begin
        if ({data, rev_low} != revision_expected) begin
          se_valid_next = 1'b1;
          se_field_next = 5'd0;
          phase_next    = tlvd_pkg::PH_ERR;
        end else begin
          phase_next      = tlvd_pkg::PH_HEAD;
          hdr_idx_next    = 3'd0;
          hdr_id_next     = 16'd0;
          bytes_left_next = 32'd0;
        end
      end
      tlvd_pkg::PH_HEAD: begin
        case (hdr_idx)
          3'd0:    hdr_id_next[7:0]       = hdr_id[7:0] | data;
          3'd1:    hdr_id_next[15:8]      = hdr_id[15:8] | data;
          3'd2:    bytes_left_next[7:0]   = bytes_left[7:0] | data;
          3'd3:    bytes_left_next[15:8]  = bytes_left[15:8] | data;
          3'd4:    bytes_left_next[23:16] = bytes_left[23:16] | data;
          3'd5:    bytes_left_next[31:24] = bytes_left[31:24] | data;
          default: ;
        endcase
        hdr_idx_next = hdr_idx + 3'd1;
        if (hdr_idx == 3'(tlvd_pkg::HDR_BYTES - 1)) begin
          if (hdr_id_next != {11'd0, exp_id}) begin
            se_valid_next = 1'b1;
            se_field_next = exp_id;
            phase_next    = tlvd_pkg::PH_ERR;
          end else begin
            if (!layout_next) begin
              if (sz != 5'd0 && bytes_left_next != {27'd0, sz}) begin
                size_bad_next[exp_id - 5'd1] = 1'b1;
              end
              if (exp_id >= tlvd_pkg::EXEC_BLOB_FIRST && exp_id <= tlvd_pkg::EXEC_BLOB_LAST &&
                  bytes_left_next > blob_limit) begin
                blob_bad_next[blob_bit[1:0]] = 1'b1;
              end
            end else begin
              if ((exp_id == 5'd1 && bytes_left_next != 32'd16) ||
                  (exp_id == 5'd2 && bytes_left_next != 32'd8) ||
                  (exp_id == 5'd4 && bytes_left_next != 32'd1)) begin
                size_bad_next[exp_id - 5'd1] = 1'b1;
              end
              if (exp_id == 5'd3 && bytes_left_next > blob_limit) begin
                blob_bad_next[0] = 1'b1;
              end
              if (exp_id == 5'd5 && bytes_left_next > blob_limit) begin
                blob_bad_next[1] = 1'b1;
              end
            end
            if (bytes_left_next == 32'd0) begin
              field_end = 1'b1;
            end else begin
              phase_next = tlvd_pkg::PH_VALUE;
            end
          end
        end
      end
      tlvd_pkg::PH_VALUE: begin
        if (layout_next && exp_id == tlvd_pkg::FETCH_BOOL_ID && !size_bad[3] &&
            data > 8'd1) begin
          bool_bad_next = 1'b1;
        end
        bytes_left_next = bytes_left - 32'd1;
        if (bytes_left_next == 32'd0) begin
          field_end = 1'b1;
        end
      end
      tlvd_pkg::PH_DONE: begin
        // Trailing bytes after the last field
        se_valid_next = 1'b1;
        se_field_next = 5'd0;
        phase_next    = tlvd_pkg::PH_ERR;
      end
      default: ;
    endcase

    if (field_end) begin
      if (exp_id >= total) begin
        phase_next = tlvd_pkg::PH_DONE;
      end else begin
        exp_id_next     = exp_id + 5'd1;
        phase_next      = tlvd_pkg::PH_HEAD;
        hdr_idx_next    = 3'd0;
        hdr_id_next     = 16'd0;
        bytes_left_next = 32'd0;
      end
    end
  end

  always_comb begin
    snap.count    = byte_count_next;
    snap.phase    = phase_next;
    snap.layout   = layout_next;
    snap.exp_id   = exp_id_next;
    snap.se_valid = se_valid_next;
    snap.se_field = se_field_next;
    snap.size_bad = size_bad_next;
    snap.blob_bad = blob_bad_next;
    snap.bool_bad = bool_bad_next;
  end

  always_comb begin
    inval = (phase == tlvd_pkg::PH_VALUE);
    fnum  = inval ? exp_id : 5'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      byte_count <= '0;
      phase      <= tlvd_pkg::PH_REV_LO;
      layout     <= 1'b0;
      rev_low    <= 8'd0;
      hdr_idx    <= 3'd0;
      exp_id     <= 5'd1;
      hdr_id     <= 16'd0;
      bytes_left <= 32'd0;
      se_valid   <= 1'b0;
      se_field   <= 5'd0;
      size_bad   <= '0;
      blob_bad   <= '0;
      bool_bad   <= 1'b0;
    end else if (step) begin
      byte_count <= byte_count_next;
      phase      <= phase_next;
      layout     <= layout_next;
      rev_low    <= rev_low_next;
      hdr_idx    <= hdr_idx_next;
      exp_id     <= exp_id_next;
      hdr_id     <= hdr_id_next;
      bytes_left <= bytes_left_next;
      se_valid   <= se_valid_next;
      se_field   <= se_field_next;
      size_bad   <= size_bad_next;
      blob_bad   <= blob_bad_next;
      bool_bad   <= bool_bad_next;
    end
  end

endmodule

FILE: rtl/core/tlvd_status.sv
// Final status priority resolution for a payload's last byte.
module tlvd_status (
  input  tlvd_pkg::snap_t snap,
  input  logic [31:0]     payload_limit,
  output logic [1:0]      status,
  output logic [4:0]      error_field
);

  logic       size_hit;
  logic [4:0] size_fld;
  logic       blob_hit;
  logic [4:0] blob_fld;

  // Lowest set flag wins: scan from the top down.
  always_comb begin
    size_hit = 1'b0;
    size_fld = 5'd0;
    for (int i = tlvd_pkg::SIZE_FLAGS - 1; i >= 0; i--) begin
      if (snap.size_bad[i]) begin
        size_hit = 1'b1;
        size_fld = 5'(i + 1);
      end
    end
    blob_hit = 1'b0;
    blob_fld = 5'd0;
    for (int j = tlvd_pkg::BLOB_FLAGS - 1; j >= 0; j--) begin
      if (snap.blob_bad[j]) begin
        blob_hit = 1'b1;
        blob_fld = tlvd_pkg::EXEC_BLOB_FIRST + 5'(j);
      end
    end
  end

  always_comb begin
    status      = tlvd_pkg::ST_OK;
    error_field = 5'd0;
    if (snap.count > {1'b0, payload_limit}) begin
      status = tlvd_pkg::ST_RESOURCE;
    end else if (snap.se_valid) begin
      status      = tlvd_pkg::ST_INVALID;
      error_field = snap.se_field;
    end else if (snap.phase == tlvd_pkg::PH_REV_LO || snap.phase == tlvd_pkg::PH_REV_HI) begin
      status = tlvd_pkg::ST_INVALID;
    end else if (snap.phase == tlvd_pkg::PH_HEAD || snap.phase == tlvd_pkg::PH_VALUE) begin
      status      = tlvd_pkg::ST_INVALID;
      error_field = snap.exp_id;
    end else if (!snap.layout) begin
      if (size_hit) begin
        status      = tlvd_pkg::ST_INVALID;
        error_field = size_fld;
      end else if (blob_hit) begin
        status      = tlvd_pkg::ST_RESOURCE;
        error_field = blob_fld;
      end
    end else begin
      if (snap.bool_bad) begin
        status      = tlvd_pkg::ST_INVALID;
        error_field = tlvd_pkg::FETCH_BOOL_ID;
      end else if (snap.size_bad[0]) begin
        status      = tlvd_pkg::ST_INVALID;
        error_field = 5'd1;
      end else if (snap.size_bad[1]) begin
        status      = tlvd_pkg::ST_INVALID;
        error_field = 5'd2;
      end else if (snap.blob_bad[0]) begin
        status      = tlvd_pkg::ST_RESOURCE;
        error_field = 5'd3;
      end else if (snap.size_bad[3]) begin
        status      = tlvd_pkg::ST_INVALID;
        error_field = 5'd4;
      end else if (snap.blob_bad[1]) begin
        status      = tlvd_pkg::ST_RESOURCE;
        error_field = 5'd5;
      end
    end
  end

endmodule

FILE: rtl/core/tlv_payload_validating_deframer.sv
// Top level of the streaming TLV payload deframer and validator.
//
// Input channel (in_valid/in_ready): one payload byte per item with its
// last-byte mark; kind picks the layout (execute or fetch) and is sampled
// only on a payload's first byte.
// Output channel (out_valid/out_ready): one result item per input item:
// the byte echoed with its field id and value flag, and on the last byte
// the final status with the blamed field id.
// Configuration: cfg_we writes cfg_data into register cfg_index (revision,
// payload limit, blob limit) at once; write only while the block is idle.
// Timing: an accepted item is held in the input register, passes the parser
// and is loaded into the result register, which raises out_valid.
// Throughput: one item per cycle while out_ready is high, set by the single
// parser pass between those two registers.
// Stall: when out_ready is low the result register holds and the input
// register still takes one more item; in_ready drops only when both are
// full. Reset clears the parser, both registers and loads the register
// defaults; the block re-arms by itself after every last byte.
module tlv_payload_validating_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  data,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  value_byte,
  output logic [4:0]  field_number,
  output logic        in_value,
  output logic        done_res,
  output logic [1:0]  status,
  output logic [4:0]  error_field
);

  // Configuration registers
  logic [15:0] revision_expected;
  logic [31:0] payload_limit;
  logic [31:0] blob_limit;

  // Input register
  logic       in_q_valid;
  logic       in_q_kind;
  logic [7:0] in_q_data;
  logic       in_q_last;

  logic advance;
  logic fire;

  tlvd_pkg::snap_t snap;
  logic [4:0]      fnum;
  logic            inval;
  logic [1:0]      st;
  logic [4:0]      efld;

  always_ff @(posedge clk) begin
    if (rst) begin
      revision_expected <= 16'd1;
      payload_limit     <= 32'h0100_0000;
      blob_limit        <= 32'h0100_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        tlvd_pkg::REG_REVISION:      revision_expected <= cfg_data[15:0];
        tlvd_pkg::REG_PAYLOAD_LIMIT: payload_limit     <= cfg_data;
        tlvd_pkg::REG_BLOB_LIMIT:    blob_limit        <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Advance the result register whenever it is empty or being taken.
  assign advance  = !out_valid || out_ready;
  assign fire     = in_q_valid && advance;
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  // Hold the input payload until the parser consumes it.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_kind <= kind;
      in_q_data <= data;
      in_q_last <= last;
    end
  end

  tlvd_parse u_parse (
    .clk               (clk),
    .rst               (rst),
    .step              (fire),
    .kind              (in_q_kind),
    .data              (in_q_data),
    .last              (in_q_last),
    .revision_expected (revision_expected),
    .blob_limit        (blob_limit),
    .snap              (snap),
    .fnum              (fnum),
    .inval             (inval)
  );

  tlvd_status u_status (
    .snap          (snap),
    .payload_limit (payload_limit),
    .status        (st),
    .error_field   (efld)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  // Status and blamed field are only reported on the last byte.
  always_ff @(posedge clk) begin
    if (fire) begin
      value_byte   <= in_q_data;
      field_number <= fnum;
      in_value     <= inval;
      done_res     <= in_q_last;
      status       <= in_q_last ? st : tlvd_pkg::ST_OK;
      error_field  <= in_q_last ? efld : 5'd0;
    end
  end

`ifndef ASSERT_OFF
  a_status_only_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> status == tlvd_pkg::ST_OK && error_field == 5'd0)
    else $error("status reported on a byte that is not the last");

  a_value_has_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_value |-> field_number != 5'd0)
    else $error("value byte without a field id");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("consumed item produced no result");
`endif

endmodule

FILE: verif/tlv_payload_validating_deframer_tb.sv
// Self-checking testbench for the TLV payload deframer: directed table, then random payloads.
module tlv_payload_validating_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Run limits and pressure knobs
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int HOLD_CYCLES    = 60;    // long receiver hold-off, fills the block
  localparam int HOLD_AT        = 60;    // item of each phase that starts the hold-off
  localparam int TAIL_CYCLES    = 10;    // settle time after the last result

  // Index past the register list; writes to it must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Fixed value length of each execute field, 0 for a variable blob.
  localparam logic [4:0] EXEC_LEN [1:19] = '{
    5'd1, 5'd16, 5'd16, 5'd8, 5'd16, 5'd8, 5'd0, 5'd0, 5'd0, 5'd0,
    5'd16, 5'd2, 5'd8, 5'd8, 5'd8, 5'd16, 5'd16, 5'd16, 5'd16};

  typedef enum int {
    FLOW_FREE,
    FLOW_SENDER_GAPS,
    FLOW_RECEIVER_STALLS,
    FLOW_BOTH
  } flow_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic [4:0] field_number;
    logic       in_value;
    logic       done_res;
    logic [1:0] status;
    logic [4:0] error_field;
  } result_t;

  typedef struct packed {
    logic    kind_v;
    logic [7:0] data_v;
    logic    last_v;
    bit      typed;   // 1: use the result typed in the row, not the prediction
    result_t want;
  } row_t;

  // Directed payloads, one byte per row. Typed results only where obvious.
  localparam row_t DIRECTED [22] = '{
    // Execute payload cut after one byte: revision missing.
    '{1'b0, 8'h01, 1'b1, 1'b1, '{8'h01, 5'd0, 1'b0, 1'b1, tlvd_pkg::ST_INVALID, 5'd0}},
    // Fetch payload ends right after a good revision: field 1 header missing.
    '{1'b1, 8'h01, 1'b0, 1'b0, '0},
    '{1'b0, 8'h00, 1'b1, 1'b1, '{8'h00, 5'd0, 1'b0, 1'b1, tlvd_pkg::ST_INVALID, 5'd1}},
    // Wrong revision word.
    '{1'b0, 8'hff, 1'b0, 1'b0, '0},
    '{1'b1, 8'hff, 1'b1, 1'b1, '{8'hff, 5'd0, 1'b0, 1'b1, tlvd_pkg::ST_INVALID, 5'd0}},
    // Execute: first header carries id 2 where id 1 is due.
    '{1'b0, 8'h01, 1'b0, 1'b0, '0},
    '{1'b1, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 8'h02, 1'b0, 1'b0, '0},
    '{1'b1, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 8'h00, 1'b1, 1'b1, '{8'h00, 5'd0, 1'b0, 1'b1, tlvd_pkg::ST_INVALID, 5'd1}},
    // Fetch: field 1 with a one-byte value, then the payload stops.
    '{1'b1, 8'h01, 1'b0, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 8'h01, 1'b0, 1'b0, '0},
    '{1'b1, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 8'h01, 1'b0, 1'b0, '0},
    '{1'b1, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 8'ha5, 1'b1, 1'b1, '{8'ha5, 5'd1, 1'b1, 1'b1, tlvd_pkg::ST_INVALID, 5'd2}}};

  // DUT signals; every input is known from time zero.
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = tlvd_pkg::REG_REVISION;
  logic [31:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        kind      = 1'b0;
  logic [7:0]  data      = '0;
  logic        last      = 1'b0;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  value_byte;
  logic [4:0]  field_number;
  logic        in_value;
  logic        done_res;
  logic [1:0]  status;
  logic [4:0]  error_field;

  tlv_payload_validating_deframer i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .data         (data),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value_byte   (value_byte),
    .field_number (field_number),
    .in_value     (in_value),
    .done_res     (done_res),
    .status       (status),
    .error_field  (error_field)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Deframer predictor: its own copy of the registers and parser state.
  // ---------------------------------------------------------------------
  logic [15:0] cfg_revision;
  logic [31:0] cfg_payload_limit;
  logic [31:0] cfg_blob_limit;

  logic [32:0]       cnt_bytes;
  tlvd_pkg::phase_t  cur_phase;
  logic              layout;        // 0 execute, 1 fetch
  logic [7:0]        rev_low;
  logic [2:0]        hdr_idx;
  logic [4:0]        want_id;
  logic [15:0]       hdr_id;
  logic [31:0]       len_left;      // holds the length while the header arrives
  logic              struct_err;
  logic [4:0]        struct_err_field;
  logic [18:0]       size_bad;      // bit id-1
  logic [3:0]        blob_bad;
  logic              bool_bad;

  result_t        expected_results[$];
  logic [7:0]     payload_bytes[$];
  flow_t          flow = FLOW_FREE;
  int             hold_left = 0;
  int             items_sent = 0;
  int             errors = 0;
  int             idle_cycles = 0;
  result_t        front_result;

  // Append one expectation at the back of the result queue.
  task automatic add_expected(input result_t r);
    expected_results = {expected_results, r};
  endtask

  // Append one byte at the end of the payload under construction.
  task automatic add_byte(input logic [7:0] b);
    payload_bytes = {payload_bytes, b};
  endtask

  task automatic clear_payload();
    cnt_bytes        = '0;
    cur_phase        = tlvd_pkg::PH_REV_LO;
    layout           = 1'b0;
    rev_low          = '0;
    hdr_idx          = '0;
    want_id          = 5'd1;
    hdr_id           = '0;
    len_left         = '0;
    struct_err       = 1'b0;
    struct_err_field = '0;
    size_bad         = '0;
    blob_bad         = '0;
    bool_bad         = 1'b0;
  endtask

  task automatic flag_error(input logic [4:0] fld);
    struct_err       = 1'b1;
    struct_err_field = fld;
    cur_phase        = tlvd_pkg::PH_ERR;
  endtask

  task automatic begin_header();
    cur_phase = tlvd_pkg::PH_HEAD;
    hdr_idx   = '0;
    hdr_id    = '0;
    len_left  = '0;
  endtask

  // Advance to the next header, or to the done phase after the last field.
  task automatic end_field();
    if (want_id >= (layout ? tlvd_pkg::FETCH_FIELDS : tlvd_pkg::EXEC_FIELDS)) begin
      cur_phase = tlvd_pkg::PH_DONE;
    end else begin
      want_id++;
      begin_header();
    end
  endtask

  // Header complete: check the id, record length faults, then enter the value or end an empty field.
  task automatic close_header();
    if (hdr_id != 16'(want_id)) begin
      flag_error(want_id);
      return;
    end
    if (!layout) begin
      if (want_id >= 5'd1 && want_id <= tlvd_pkg::EXEC_FIELDS &&
          EXEC_LEN[want_id] != 5'd0 && len_left != 32'(EXEC_LEN[want_id]))
        size_bad[want_id - 5'd1] = 1'b1;
      if (want_id >= tlvd_pkg::EXEC_BLOB_FIRST && want_id <= tlvd_pkg::EXEC_BLOB_LAST &&
          len_left > cfg_blob_limit)
        blob_bad[want_id - tlvd_pkg::EXEC_BLOB_FIRST] = 1'b1;
    end else begin
      if ((want_id == 5'd1 && len_left != 32'd16) ||
          (want_id == 5'd2 && len_left != 32'd8) ||
          (want_id == tlvd_pkg::FETCH_BOOL_ID && len_left != 32'd1))
        size_bad[want_id - 5'd1] = 1'b1;
      if (want_id == 5'd3 && len_left > cfg_blob_limit)
        blob_bad[0] = 1'b1;
      if (want_id == 5'd5 && len_left > cfg_blob_limit)
        blob_bad[1] = 1'b1;
    end
    if (len_left == '0)
      end_field();
    else
      cur_phase = tlvd_pkg::PH_VALUE;
  endtask

  // Status on the last byte, in priority order.
  task automatic final_status(output logic [1:0] st, output logic [4:0] fld);
    st  = tlvd_pkg::ST_OK;
    fld = 5'd0;
    if (cnt_bytes > {1'b0, cfg_payload_limit}) begin
      st = tlvd_pkg::ST_RESOURCE;
    end else if (struct_err) begin
      st  = tlvd_pkg::ST_INVALID;
      fld = struct_err_field;
    end else if (cur_phase == tlvd_pkg::PH_REV_LO || cur_phase == tlvd_pkg::PH_REV_HI) begin
      st = tlvd_pkg::ST_INVALID;
    end else if (cur_phase == tlvd_pkg::PH_HEAD || cur_phase == tlvd_pkg::PH_VALUE) begin
      st  = tlvd_pkg::ST_INVALID;
      fld = want_id;
    end else if (!layout) begin
      // Walk downward so the lowest flagged id is the one left standing.
      for (int i = tlvd_pkg::SIZE_FLAGS - 1; i >= 0; i--)
        if (size_bad[i]) begin
          st  = tlvd_pkg::ST_INVALID;
          fld = 5'(i + 1);
        end
      if (st == tlvd_pkg::ST_OK)
        for (int i = tlvd_pkg::BLOB_FLAGS - 1; i >= 0; i--)
          if (blob_bad[i]) begin
            st  = tlvd_pkg::ST_RESOURCE;
            fld = 5'(i) + tlvd_pkg::EXEC_BLOB_FIRST;
          end
    end else if (bool_bad) begin
      st  = tlvd_pkg::ST_INVALID;
      fld = tlvd_pkg::FETCH_BOOL_ID;
    end else if (size_bad[0]) begin
      st  = tlvd_pkg::ST_INVALID;
      fld = 5'd1;
    end else if (size_bad[1]) begin
      st  = tlvd_pkg::ST_INVALID;
      fld = 5'd2;
    end else if (blob_bad[0]) begin
      st  = tlvd_pkg::ST_RESOURCE;
      fld = 5'd3;
    end else if (size_bad[tlvd_pkg::FETCH_BOOL_ID - 5'd1]) begin
      st  = tlvd_pkg::ST_INVALID;
      fld = tlvd_pkg::FETCH_BOOL_ID;
    end else if (blob_bad[1]) begin
      st  = tlvd_pkg::ST_RESOURCE;
      fld = 5'd5;
    end
  endtask

  // Work out the result item for one accepted byte and advance the state.
  task automatic predict_byte(input logic k, input logic [7:0] d, input logic l,
                              output result_t r);
    int slot;
    r            = '0;
    r.value_byte = d;
    r.done_res   = l;
    if (cnt_bytes == '0)
      layout = k;
    if (cnt_bytes != '1)
      cnt_bytes++;
    case (cur_phase)
      tlvd_pkg::PH_REV_LO: begin
        rev_low   = d;
        cur_phase = tlvd_pkg::PH_REV_HI;
      end
      tlvd_pkg::PH_REV_HI: begin
        if ({d, rev_low} != cfg_revision)
          flag_error(5'd0);
        else
          begin_header();
      end
      tlvd_pkg::PH_HEAD: begin
        slot = hdr_idx;
        if (slot < 2)
          hdr_id[slot*8 +: 8] = d;
        else
          len_left[(slot-2)*8 +: 8] = d;
        hdr_idx++;
        if (hdr_idx >= tlvd_pkg::HDR_BYTES)
          close_header();
      end
      tlvd_pkg::PH_VALUE: begin
        r.field_number = want_id;
        r.in_value     = 1'b1;
        if (layout && want_id == tlvd_pkg::FETCH_BOOL_ID &&
            !size_bad[tlvd_pkg::FETCH_BOOL_ID - 5'd1] && d > 8'd1)
          bool_bad = 1'b1;
        len_left--;
        if (len_left == '0)
          end_field();
      end
      tlvd_pkg::PH_DONE: flag_error(5'd0);  // bytes after field N
      default: ;
    endcase
    if (l) begin
      final_status(r.status, r.error_field);
      clear_payload();
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic int gap_pct(input flow_t f);
    case (f)
      FLOW_SENDER_GAPS: return 46;
      FLOW_BOTH:        return 13;
      default:          return 0;
    endcase
  endfunction

  function automatic int stall_pct(input flow_t f);
    case (f)
      FLOW_RECEIVER_STALLS: return 46;
      FLOW_BOTH:            return 13;
      default:              return 0;
    endcase
  endfunction

  // Offer one item, wait for the handshake, queue what it should produce.
  // Enter and leave at a falling edge; valid stays high into the next item.
  task automatic send_item(input logic k, input logic [7:0] d, input logic l,
                           input bit typed, input result_t typed_result, input bit hold);
    result_t predicted;
    while ($urandom_range(99) < gap_pct(flow)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    data     <= d;
    last     <= l;
    do @(posedge clk); while (!in_ready);
    predict_byte(k, d, l, predicted);
    add_expected(typed ? typed_result : predicted);
    items_sent++;
    // Start the long hold-off here so the receiver sees it at the next falling edge.
    if (hold)
      hold_left = HOLD_CYCLES;
    @(negedge clk);
  endtask

  // Write all three registers, plus an out-of-range index when asked.
  // Hold the enable high across the burst and drop it once at the end.
  task automatic set_config(input logic [15:0] rev, input logic [31:0] plim,
                            input logic [31:0] blim, input bit poke_unused);
    cfg_we    <= 1'b1;
    cfg_index <= tlvd_pkg::REG_REVISION;
    cfg_data  <= {16'($urandom), rev};  // upper bits must be dropped
    @(negedge clk);
    cfg_index <= tlvd_pkg::REG_PAYLOAD_LIMIT;
    cfg_data  <= plim;
    @(negedge clk);
    cfg_index <= tlvd_pkg::REG_BLOB_LIMIT;
    cfg_data  <= blim;
    @(negedge clk);
    if (poke_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= $urandom;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cfg_revision      = rev;
    cfg_payload_limit = plim;
    cfg_blob_limit    = blim;
  endtask

  // Drop valid and wait until every queued result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Build one payload into payload_bytes. Mostly well-formed with random
  // content; some noise, bad revisions, wrong ids, wrong lengths, huge
  // extents, trailing bytes and truncations.
  task automatic build_payload(output logic first_kind);
    logic [15:0] rev;
    logic [15:0] id;
    logic [31:0] len;
    logic [4:0]  n_fields;
    bit          huge;
    int          keep;
    payload_bytes.delete();
    first_kind = ($urandom_range(99) < 12) ? 1'b0 : 1'b1;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
      return;
    end
    rev = ($urandom_range(99) < 6) ? 16'($urandom) : cfg_revision;
    add_byte(rev[7:0]);
    add_byte(rev[15:8]);
    n_fields = first_kind ? tlvd_pkg::FETCH_FIELDS : tlvd_pkg::EXEC_FIELDS;
    for (int f = 1; f <= n_fields; f++) begin
      if (first_kind) begin
        case (f)
          1:                       len = 32'd16;
          2:                       len = 32'd8;
          tlvd_pkg::FETCH_BOOL_ID: len = 32'd1;
          default:                 len = 32'($urandom_range(0, 6));
        endcase
      end else begin
        len = (EXEC_LEN[f] != 5'd0) ? 32'(EXEC_LEN[f]) : 32'($urandom_range(0, 6));
      end
      id = ($urandom_range(99) < 3) ? 16'($urandom) : 16'(f);
      if ($urandom_range(99) < 6)
        len = $urandom_range(0, 20);
      huge = ($urandom_range(99) < 2);
      if (huge)
        len = $urandom;
      add_byte(id[7:0]);
      add_byte(id[15:8]);
      for (int b = 0; b < 4; b++)
        add_byte(len[b*8 +: 8]);
      if (huge) begin
        // Value runs past the end of the payload.
        repeat ($urandom_range(0, 8)) add_byte(8'($urandom));
        return;
      end
      for (int b = 0; b < len; b++)
        add_byte((first_kind && f == tlvd_pkg::FETCH_BOOL_ID &&
                  $urandom_range(99) < 75) ?
                 8'($urandom_range(0, 1)) : 8'($urandom));
    end
    if ($urandom_range(99) < 10)
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
    if ($urandom_range(99) < 20) begin
      keep = $urandom_range(1, payload_bytes.size());
      while (payload_bytes.size() > keep)
        void'(payload_bytes.pop_back());
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls per phase, plus the long hold-off on request.
  // ---------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct(flow));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: compare each result item with the oldest expectation.
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing expected, expected none, got byte %0h",
                 $time, value_byte);
      end else begin
        front_result = expected_results.pop_front();
        check_field("value_byte",   front_result.value_byte,   value_byte);
        check_field("field_number", front_result.field_number, field_number);
        check_field("in_value",     front_result.in_value,     in_value);
        check_field("done_res",     front_result.done_res,     done_res);
        check_field("status",       front_result.status,       status);
        check_field("error_field",  front_result.error_field,  error_field);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tlv_payload_validating_deframer: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int        phase_start;
    int        target;
    logic      first_kind;
    cfg_revision      = 16'd1;
    cfg_payload_limit = 32'd16777216;
    cfg_blob_limit    = 32'd16777216;
    clear_payload();

    // Hold reset, then release it at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table under the reset register values.
    foreach (DIRECTED[i])
      send_item(DIRECTED[i].kind_v, DIRECTED[i].data_v, DIRECTED[i].last_v,
                DIRECTED[i].typed, DIRECTED[i].want, 1'b0);

    // Random phases: each after the first drains and reprograms the registers; each sets the flow.
    for (int p = 0; p < 5; p++) begin
      if (p > 0)
        drain_results();
      case (p)
        0: begin
          flow   = FLOW_FREE;  // reset register values, no random gaps or stalls
          target = 300;
        end
        1: begin
          set_config(16'hffff, 32'hffff_ffff, 32'd0, 1'b0);
          flow   = FLOW_SENDER_GAPS;
          target = 300;
        end
        2: begin
          set_config(16'h0000, 32'($urandom_range(40, 400)), 32'd3, 1'b1);
          flow   = FLOW_RECEIVER_STALLS;
          target = 300;
        end
        3: begin
          // Payload limit of two bytes: nearly everything is oversize.
          set_config(16'($urandom), 32'd2, 32'hffff_ffff, 1'b0);
          flow   = FLOW_BOTH;
          target = 100;
        end
        default: begin
          set_config(16'd1, 32'd16777216, 32'd5, 1'b0);
          flow   = FLOW_BOTH;
          target = 300;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < target) begin
        build_payload(first_kind);
        // Kind only matters on the first byte; randomize it elsewhere.
        foreach (payload_bytes[i])
          send_item(i == 0 ? first_kind : 1'($urandom), payload_bytes[i],
                    i == payload_bytes.size() - 1, 1'b0, '0,
                    items_sent - phase_start == HOLD_AT);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("tlv_payload_validating_deframer: match");
    else
      $display("tlv_payload_validating_deframer: mismatch");
    $finish;
  end

endmodule
